FILE: rtl/lcd_mode_timing_controller_top_macros.svh
// assertion macros shared by the lcd mode timing controller rtl
// depends on nothing; included by files that carry concurrent assertions
`ifndef LCD_MODE_TIMING_CONTROLLER_TOP_MACROS_SVH
`define LCD_MODE_TIMING_CONTROLLER_TOP_MACROS_SVH

// checked on every rising clock edge, muted while reset is high
`define LMTC_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked on every rising clock edge, reset included
`define LMTC_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: rtl/lmtc_pkg.sv
// types and timing constants for the lcd mode timing controller
// no dependencies; imported by lcd_mode_timing_controller_top
`timescale 1ns / 1ps

package lmtc_pkg;

   // frame and line timing in machine cycles
   localparam logic [16:0] FRAME_CYCLES = 17'd70224;
   localparam logic [16:0] VBLANK_START = 17'd65664;
   localparam logic [9:0]  LINE_CYCLES  = 10'd456;
   localparam logic [8:0]  OAM_END      = 9'd80;
   localparam logic [8:0]  XFER_LEN     = 9'd172;
   localparam logic [8:0]  XFER_END     = OAM_END + XFER_LEN;

   // line number = (frame position * scale) >> 24
   localparam int unsigned LINE_SCALE_INT = 32'h0100_0000 / 32'd456;
   localparam logic [15:0] LINE_SCALE     = 16'(LINE_SCALE_INT);
   localparam int          LINE_SHIFT     = 24;

   // scaled display window, lines strictly between these bounds
   localparam logic [7:0]  SCALED_LOW   = 8'd2;
   localparam logic [7:0]  SCALED_LIMIT = 8'd155;

   // frameskip counter reload
   localparam logic [1:0]  SKIP_RELOAD = 2'd2;

   // register indexes
   localparam logic        REG_SCALED_OUTPUT = 1'b0;

   typedef enum logic [1:0] {
      MODE_HBLANK = 2'd0,
      MODE_VBLANK = 2'd1,
      MODE_OAM    = 2'd2,
      MODE_XFER   = 2'd3
   } mode_type;

   // what the timing stage hands to the line stage for one beat
   typedef struct packed {
      logic [16:0] frame_pos;
      logic        lcd_on;
      logic [7:0]  compare_line;
      logic        match_int_en;
      logic        vblank_irq;
      logic        stat_irq;
      logic        hblank_entry;
      logic        skip_zero;
      mode_type    mode;
      logic [31:0] frames_done;
   } stage_type;

endpackage

FILE: rtl/lcd_mode_timing_controller_top.sv
// lcd mode timing controller: frame/line counters, mode tracking, irqs, draw requests
// depends on lmtc_pkg and lcd_mode_timing_controller_top_macros.svh
`timescale 1ns / 1ps
// an accepted beat is registered in p1, then in the output register once that is free
// throughput: one beat per cycle unless stalled; set by the frame and line counter
//   loop in the timing stage and the single 17x16 line multiplier in the line stage
// reset: synchronous, active high; all counters, mode and flags clear to zero,
//   scaled_output returns to one and both pipeline stages empty

`include "lcd_mode_timing_controller_top_macros.svh"

module lcd_mode_timing_controller_top (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_cycles,
   input  logic        req_lcd_on,
   input  logic [7:0]  req_compare_line,
   input  logic        req_hblank_int_en,
   input  logic        req_oam_int_en,
   input  logic        req_match_int_en,
   // response channel
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_line,
   output logic [1:0]  rsp_lcd_mode,
   output logic        rsp_coincidence,
   output logic        rsp_vblank_irq,
   output logic        rsp_stat_irq,
   output logic        rsp_draw_line,
   output logic [31:0] rsp_frames_done,
   // configuration port
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   import lmtc_pkg::*;

   // ---------------------------------------------------------------------
   // state
   // ---------------------------------------------------------------------
   logic            scaled_ff,     scaled_in;
   logic [16:0]     frame_ff,      frame_in;
   logic [8:0]      line_clock_ff, line_clock_in;
   mode_type        mode_ff,       mode_in;
   logic [1:0]      skip_ff,       skip_in;
   logic [31:0]     total_ff,      total_in;
   logic            match_ff,      match_in;
   logic [7:0]      last_drawn_ff, last_drawn_in;

   // pipeline
   logic            p1_valid_ff,   p1_valid_in;
   stage_type       p1_ff,         p1_in;
   logic            rsp_valid_ff,  rsp_valid_in;

   // response payload
   logic [7:0]      rsp_line_ff,   rsp_line_in;
   mode_type        rsp_mode_ff,   rsp_mode_in;
   logic            rsp_coin_ff,   rsp_coin_in;
   logic            rsp_vbl_ff,    rsp_vbl_in;
   logic            rsp_stat_ff,   rsp_stat_in;
   logic            rsp_draw_ff,   rsp_draw_in;
   logic [31:0]     rsp_total_ff,  rsp_total_in;

   // handshake
   logic            req_accept;
   logic            out_free;
   logic            p1_move;
   logic            csr_write;

   // timing stage working values
   logic [16:0]     fc_sum;
   logic            fc_wrap;
   logic [16:0]     fc_new;
   logic            in_vblank;
   logic [8:0]      lc_base;
   logic [9:0]      lc_sum;
   logic [8:0]      lc_adv;
   logic            oam_entry;
   logic            hb_entry;

   // line stage working values
   logic [32:0]     line_prod;
   logic [7:0]      cur_line;
   logic            line_stat;
   logic            line_draw;
   logic            in_window;

   // ---------------------------------------------------------------------
   // handshakes: output register parts the two sides, so a new beat is
   // taken while the previous result still waits
   // ---------------------------------------------------------------------
   assign out_free   = !rsp_valid_ff || rsp_ready;
   assign p1_move    = p1_valid_ff && out_free;
   assign req_ready  = !p1_valid_ff || p1_move;
   assign req_accept = req_valid && req_ready;

   // ---------------------------------------------------------------------
   // configuration register, always ready
   // ---------------------------------------------------------------------
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_prdata = (csr_paddr[2] == REG_SCALED_OUTPUT) ? {31'd0, scaled_ff} : 32'd0;

   always_comb begin
      scaled_in = scaled_ff;
      if (csr_write && (csr_paddr[2] == REG_SCALED_OUTPUT)) begin
         scaled_in = csr_pwdata[0];
      end
   end

   // ---------------------------------------------------------------------
   // timing stage: frame and line counters, mode, vblank and entry irqs
   // ---------------------------------------------------------------------
   always_comb begin
      fc_sum  = frame_ff + 17'(req_cycles);
      fc_wrap = fc_sum >= FRAME_CYCLES;
      fc_new  = fc_wrap ? (fc_sum - FRAME_CYCLES) : fc_sum;
      // after a wrap the frame position is below 255, never in vblank
      in_vblank = !fc_wrap && (fc_sum >= VBLANK_START);
      // on wrap the line counter restarts from the leftover frame position
      lc_base = fc_wrap ? fc_new[8:0] : line_clock_ff;
      lc_sum  = 10'(lc_base) + 10'(req_cycles);
      // one subtraction is enough: the sum stays below twice a line
      lc_adv  = (lc_sum >= LINE_CYCLES) ? 9'(lc_sum - LINE_CYCLES) : lc_sum[8:0];
   end

   always_comb begin
      frame_in      = frame_ff;
      line_clock_in = line_clock_ff;
      mode_in       = mode_ff;
      skip_in       = skip_ff;
      total_in      = total_ff;
      oam_entry     = 1'b0;
      hb_entry      = 1'b0;
      p1_in         = p1_ff;

      if (req_accept) begin
         frame_in = fc_new;
         total_in = fc_wrap ? (total_ff + 32'd1) : total_ff;
         p1_in.vblank_irq = 1'b0;

         if (in_vblank) begin
            // line counter held through vblank
            if (mode_ff != MODE_VBLANK) begin
               mode_in          = MODE_VBLANK;
               p1_in.vblank_irq = 1'b1;
               skip_in          = (skip_ff == 2'd0) ? SKIP_RELOAD : (skip_ff - 2'd1);
            end
         end else begin
            line_clock_in = lc_adv;
            if (lc_adv <= OAM_END) begin
               if (mode_ff != MODE_OAM) begin
                  mode_in   = MODE_OAM;
                  oam_entry = 1'b1;
               end
            end else if (lc_adv <= XFER_END) begin
               mode_in = MODE_XFER;
            end else if (mode_ff != MODE_HBLANK) begin
               mode_in  = MODE_HBLANK;
               hb_entry = 1'b1;
            end
         end

         p1_in.frame_pos    = fc_new;
         p1_in.lcd_on       = req_lcd_on;
         p1_in.compare_line = req_compare_line;
         p1_in.match_int_en = req_match_int_en;
         p1_in.stat_irq     = (oam_entry && req_oam_int_en) ||
                              (hb_entry && req_hblank_int_en);
         p1_in.hblank_entry = hb_entry;
         // skip count only moves on vblank entry, so the held value applies
         p1_in.skip_zero    = (skip_ff == 2'd0);
         p1_in.mode         = mode_in;
         p1_in.frames_done  = total_in;
      end
   end

   // ---------------------------------------------------------------------
   // line stage: line number, coincidence and draw request
   // ---------------------------------------------------------------------
   always_comb begin
      line_prod = 33'(p1_ff.frame_pos) * 33'(LINE_SCALE);
      cur_line  = line_prod[LINE_SHIFT +: 8];
      in_window = (cur_line > SCALED_LOW) && (cur_line < SCALED_LIMIT);

      match_in      = match_ff;
      last_drawn_in = last_drawn_ff;
      line_stat     = p1_ff.stat_irq;
      line_draw     = 1'b0;

      if (p1_move) begin
         // coincidence only tracked while the display runs
         if (p1_ff.lcd_on) begin
            if (cur_line == p1_ff.compare_line) begin
               if (!match_ff) begin
                  match_in = 1'b1;
                  if (p1_ff.match_int_en) begin
                     line_stat = 1'b1;
                  end
               end
            end else begin
               match_in = 1'b0;
            end
         end

         // a new line entering hblank; skipped frames still mark it drawn
         if (p1_ff.hblank_entry && p1_ff.lcd_on && (last_drawn_ff != cur_line)) begin
            if (p1_ff.skip_zero) begin
               line_draw = scaled_ff ? in_window : 1'b1;
            end
            last_drawn_in = cur_line;
         end
      end
   end

   always_comb begin
      rsp_line_in  = rsp_line_ff;
      rsp_mode_in  = rsp_mode_ff;
      rsp_coin_in  = rsp_coin_ff;
      rsp_vbl_in   = rsp_vbl_ff;
      rsp_stat_in  = rsp_stat_ff;
      rsp_draw_in  = rsp_draw_ff;
      rsp_total_in = rsp_total_ff;
      if (p1_move) begin
         rsp_line_in  = cur_line;
         rsp_mode_in  = p1_ff.mode;
         rsp_coin_in  = match_in;
         rsp_vbl_in   = p1_ff.vblank_irq;
         rsp_stat_in  = line_stat;
         rsp_draw_in  = line_draw;
         rsp_total_in = p1_ff.frames_done;
      end
   end

   // stage occupancy
   always_comb begin
      if (req_accept) begin
         p1_valid_in = 1'b1;
      end else if (p1_move) begin
         p1_valid_in = 1'b0;
      end else begin
         p1_valid_in = p1_valid_ff;
      end

      if (p1_move) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // ---------------------------------------------------------------------
   // registers
   // ---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         scaled_ff     <= 1'b1;
         frame_ff      <= '0;
         line_clock_ff <= '0;
         mode_ff       <= MODE_HBLANK;
         skip_ff       <= '0;
         total_ff      <= '0;
         match_ff      <= 1'b0;
         last_drawn_ff <= '0;
         p1_valid_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         scaled_ff     <= scaled_in;
         frame_ff      <= frame_in;
         line_clock_ff <= line_clock_in;
         mode_ff       <= mode_in;
         skip_ff       <= skip_in;
         total_ff      <= total_in;
         match_ff      <= match_in;
         last_drawn_ff <= last_drawn_in;
         p1_valid_ff   <= p1_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // payload, no reset needed
   always_ff @(posedge clock) begin
      p1_ff        <= p1_in;
      rsp_line_ff  <= rsp_line_in;
      rsp_mode_ff  <= rsp_mode_in;
      rsp_coin_ff  <= rsp_coin_in;
      rsp_vbl_ff   <= rsp_vbl_in;
      rsp_stat_ff  <= rsp_stat_in;
      rsp_draw_ff  <= rsp_draw_in;
      rsp_total_ff <= rsp_total_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_line        = rsp_line_ff;
   assign rsp_lcd_mode    = rsp_mode_ff;
   assign rsp_coincidence = rsp_coin_ff;
   assign rsp_vblank_irq  = rsp_vbl_ff;
   assign rsp_stat_irq    = rsp_stat_ff;
   assign rsp_draw_line   = rsp_draw_ff;
   assign rsp_frames_done = rsp_total_ff;

   // ---------------------------------------------------------------------
   // assertions
   // ---------------------------------------------------------------------
   `LMTC_ASSERT(a_frame_range, clock, reset, frame_ff < FRAME_CYCLES, "frame counter out of range")
   `LMTC_ASSERT(a_line_clock_range, clock, reset, 10'(line_clock_ff) < LINE_CYCLES, "line counter out of range")
   `LMTC_ASSERT(a_vbl_mode, clock, reset, rsp_valid_ff && rsp_vbl_ff |-> rsp_mode_ff == MODE_VBLANK, "vblank irq outside vblank")
   `LMTC_ASSERT(a_draw_mode, clock, reset, rsp_valid_ff && rsp_draw_ff |-> rsp_mode_ff == MODE_HBLANK, "draw request outside hblank")
   `LMTC_ASSERT(a_line_range, clock, reset, rsp_valid_ff |-> rsp_line_ff < 8'd154, "line number out of range")
   `LMTC_ASSERT_ALWAYS(a_reset_empty, clock, reset |=> !rsp_valid_ff && !p1_valid_ff, "pipeline not empty after reset")

endmodule

FILE: tb/lcd_mode_timing_controller_top_tb.sv
// self-checking testbench for lcd_mode_timing_controller_top: frame, line and mode timing
// depends on lmtc_pkg and the rtl top; predicts each response beat and compares all fields
`timescale 1ns / 1ps

module lcd_mode_timing_controller_top_tb;
   import lmtc_pkg::*;

   localparam int          RUN_LIMIT   = 400000;  // cycles before the watchdog gives up
   localparam int          LONG_STALL  = 400;     // receiver hold-off length in cycles
   localparam int          DRAIN_WAIT  = 16;      // well past the drain of the p1 and response registers
   localparam int          SHOWN_ERRS  = 10;
   localparam logic [2:0]  ADDR_SCALED = 3'(4 * int'(REG_SCALED_OUTPUT));
   localparam logic [2:0]  ADDR_SPARE  = 3'd4;    // index one, not a register

   // one request beat
   typedef struct packed {
      logic [7:0] cycles;
      logic       lcd_on;
      logic [7:0] compare_line;
      logic       hblank_int_en;
      logic       oam_int_en;
      logic       match_int_en;
   } timing_beat_type;

   // one response beat
   typedef struct packed {
      logic [7:0]  line;
      mode_type    lcd_mode;
      logic        coincidence;
      logic        vblank_irq;
      logic        stat_irq;
      logic        draw_line;
      logic [31:0] frames_done;
   } timing_view_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [7:0]  req_cycles = '0;
   logic        req_lcd_on = 1'b0;
   logic [7:0]  req_compare_line = '0;
   logic        req_hblank_int_en = 1'b0;
   logic        req_oam_int_en = 1'b0;
   logic        req_match_int_en = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [7:0]  rsp_line;
   logic [1:0]  rsp_lcd_mode;
   logic        rsp_coincidence;
   logic        rsp_vblank_irq;
   logic        rsp_stat_irq;
   logic        rsp_draw_line;
   logic [31:0] rsp_frames_done;
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [2:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   lcd_mode_timing_controller_top dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_cycles        (req_cycles),
      .req_lcd_on        (req_lcd_on),
      .req_compare_line  (req_compare_line),
      .req_hblank_int_en (req_hblank_int_en),
      .req_oam_int_en    (req_oam_int_en),
      .req_match_int_en  (req_match_int_en),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_line          (rsp_line),
      .rsp_lcd_mode      (rsp_lcd_mode),
      .rsp_coincidence   (rsp_coincidence),
      .rsp_vblank_irq    (rsp_vblank_irq),
      .rsp_stat_irq      (rsp_stat_irq),
      .rsp_draw_line     (rsp_draw_line),
      .rsp_frames_done   (rsp_frames_done),
      .csr_psel          (csr_psel),
      .csr_penable       (csr_penable),
      .csr_pwrite        (csr_pwrite),
      .csr_paddr         (csr_paddr),
      .csr_pwdata        (csr_pwdata),
      .csr_prdata        (csr_prdata),
      .csr_pready        (csr_pready)
   );

   // 8 ns period
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // ---------------------------------------------------------------------------------
   // timing predictor: its own copy of the counters, mode and flags
   // ---------------------------------------------------------------------------------
   logic [16:0] tm_frame_pos;
   logic [9:0]  tm_line_pos;
   logic [7:0]  tm_line;
   mode_type    tm_mode;
   logic        tm_match;
   logic [1:0]  tm_skip;
   logic [7:0]  tm_last_drawn;
   logic [31:0] tm_frames;
   logic        tm_scaled;

   timing_view_type timing_expect_q[$];

   function automatic timing_view_type advance_timing(input timing_beat_type b);
      timing_view_type v;
      logic [17:0]  frame_sum;
      logic [63:0]  scaled_pos;
      v = '0;
      frame_sum = 18'(tm_frame_pos) + 18'(b.cycles);
      // frame wrap: count it and restart the line clock from the overshoot
      if (frame_sum >= 18'(FRAME_CYCLES)) begin
         frame_sum   = frame_sum - 18'(FRAME_CYCLES);
         tm_frames   = tm_frames + 32'd1;
         tm_line_pos = 10'(frame_sum);
      end
      tm_frame_pos = frame_sum[16:0];
      scaled_pos   = 64'(tm_frame_pos) * 64'(LINE_SCALE);
      tm_line      = 8'(scaled_pos >> LINE_SHIFT);

      // coincidence only moves while the display is on
      if (b.lcd_on) begin
         if (tm_line == b.compare_line) begin
            if (!tm_match) begin
               tm_match = 1'b1;
               if (b.match_int_en) v.stat_irq = 1'b1;
            end
         end else begin
            tm_match = 1'b0;
         end
      end

      if (tm_frame_pos >= VBLANK_START) begin
         // line clock frozen during vblank
         if (tm_mode != MODE_VBLANK) begin
            tm_mode      = MODE_VBLANK;
            v.vblank_irq = 1'b1;
            tm_skip      = (tm_skip == 2'd0) ? SKIP_RELOAD : tm_skip - 2'd1;
         end
      end else begin
         tm_line_pos = tm_line_pos + 10'(b.cycles);
         if (tm_line_pos >= LINE_CYCLES) tm_line_pos = tm_line_pos - LINE_CYCLES;
         if (tm_line_pos <= 10'(OAM_END)) begin
            if (tm_mode != MODE_OAM) begin
               tm_mode = MODE_OAM;
               if (b.oam_int_en) v.stat_irq = 1'b1;
            end
         end else if (tm_line_pos <= 10'(XFER_END)) begin
            tm_mode = MODE_XFER;
         end else if (tm_mode != MODE_HBLANK) begin
            // new line entering hblank
            if (tm_last_drawn != tm_line && b.lcd_on) begin
               if (tm_skip == 2'd0)
                  v.draw_line = tm_scaled ? (tm_line > SCALED_LOW && tm_line < SCALED_LIMIT)
                                          : 1'b1;
               tm_last_drawn = tm_line;
            end
            tm_mode = MODE_HBLANK;
            if (b.hblank_int_en) v.stat_irq = 1'b1;
         end
      end

      v.line        = tm_line;
      v.lcd_mode    = tm_mode;
      v.coincidence = tm_match;
      v.frames_done = tm_frames;
      return v;
   endfunction

   // ---------------------------------------------------------------------------------
   // bookkeeping, watchdog
   // ---------------------------------------------------------------------------------
   int mismatches = 0;
   int beats_seen = 0;
   int cycle_count = 0;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > RUN_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   // ---------------------------------------------------------------------------------
   // response checker: every accepted beat against the oldest prediction
   // ---------------------------------------------------------------------------------
   always @(posedge clock) begin
      timing_view_type want;
      timing_view_type got;
      if (!reset && rsp_valid && rsp_ready) begin
         got.line        = rsp_line;
         got.lcd_mode    = mode_type'(rsp_lcd_mode);
         got.coincidence = rsp_coincidence;
         got.vblank_irq  = rsp_vblank_irq;
         got.stat_irq    = rsp_stat_irq;
         got.draw_line   = rsp_draw_line;
         got.frames_done = rsp_frames_done;
         if (timing_expect_q.size() == 0) begin
            mismatches++;
            if (mismatches <= SHOWN_ERRS)
               $display("unexpected response beat at cycle %0d: line %0d mode %0d",
                        cycle_count, got.line, got.lcd_mode);
         end else begin
            want = timing_expect_q.pop_front();
            if (got !== want) begin
               mismatches++;
               if (mismatches <= SHOWN_ERRS)
                  $display({"beat %0d mismatch (exp/act): line %0d/%0d mode %0d/%0d ",
                            "coin %0b/%0b vbl %0b/%0b stat %0b/%0b draw %0b/%0b ",
                            "frames %0d/%0d"},
                           beats_seen, want.line, got.line, want.lcd_mode, got.lcd_mode,
                           want.coincidence, got.coincidence, want.vblank_irq,
                           got.vblank_irq, want.stat_irq, got.stat_irq, want.draw_line,
                           got.draw_line, want.frames_done, got.frames_done);
            end
         end
         beats_seen++;
      end
   end

   // ---------------------------------------------------------------------------------
   // receiver: switches at random between stall styles, plus a long hold-off
   // when a test asks for one
   // ---------------------------------------------------------------------------------
   int hold_off_asks = 0;
   int hold_off_taken = 0;
   int hold_off_left = 0;
   int stall_style = 0;
   int style_left = 0;
   int pattern_phase = 0;

   always @(posedge clock) begin
      if (hold_off_asks != hold_off_taken) begin
         hold_off_taken <= hold_off_asks;
         hold_off_left  <= LONG_STALL;
         rsp_ready      <= 1'b0;
      end else if (hold_off_left != 0) begin
         hold_off_left <= hold_off_left - 1;
         rsp_ready     <= 1'b0;
      end else begin
         if (style_left == 0) begin
            stall_style <= $urandom_range(0, 3);
            style_left  <= $urandom_range(16, 96);
         end else begin
            style_left <= style_left - 1;
         end
         pattern_phase <= (pattern_phase + 1) % 7;
         case (stall_style)
            0: rsp_ready <= 1'b1;                          // no stalls at all
            1: rsp_ready <= ($urandom_range(0, 1) != 0);
            2: rsp_ready <= (pattern_phase < 4);           // fixed periodic stall
            default: rsp_ready <= ($urandom_range(0, 7) != 0);
         endcase
      end
   end

   // ---------------------------------------------------------------------------------
   // sender side
   // ---------------------------------------------------------------------------------
   logic [7:0] burst_compare;
   logic       burst_lcd_on;

   // present one beat and hold it until accepted; valid stays high afterwards
   task automatic send_beat(input timing_beat_type b);
      req_valid         <= 1'b1;
      req_cycles        <= b.cycles;
      req_lcd_on        <= b.lcd_on;
      req_compare_line  <= b.compare_line;
      req_hblank_int_en <= b.hblank_int_en;
      req_oam_int_en    <= b.oam_int_en;
      req_match_int_en  <= b.match_int_en;
      do @(posedge clock); while (!req_ready);
      timing_expect_q.push_back(advance_timing(b));
   endtask

   task automatic sender_idle(input int gap);
      req_valid <= 1'b0;
      repeat (gap) @(posedge clock);
   endtask

   function automatic timing_beat_type mk_beat(input logic [7:0] cyc, input logic on,
                                               input logic [7:0] lyc, input logic hb,
                                               input logic oam, input logic mt);
      timing_beat_type b;
      b.cycles        = cyc;
      b.lcd_on        = on;
      b.compare_line  = lyc;
      b.hblank_int_en = hb;
      b.oam_int_en    = oam;
      b.match_int_en  = mt;
      return b;
   endfunction

   // mostly long steps so several frames go by and the frameskip counter cycles
   function automatic timing_beat_type random_beat();
      timing_beat_type b;
      int              pick;
      pick = $urandom_range(0, 99);
      if (pick < 75)      b.cycles = 8'($urandom_range(192, 255));
      else if (pick < 95) b.cycles = 8'($urandom_range(0, 255));
      else                b.cycles = 8'($urandom_range(0, 8));
      b.lcd_on = ($urandom_range(0, 31) == 0) ? ~burst_lcd_on : burst_lcd_on;
      // aim the compare line where it can actually match
      pick = $urandom_range(0, 3);
      case (pick)
         0, 1:    b.compare_line = burst_compare;
         2:       b.compare_line = 8'($urandom_range(0, 255));
         default: b.compare_line = tm_line + 8'($urandom_range(0, 1));
      endcase
      b.hblank_int_en = 1'($urandom_range(0, 1));
      b.oam_int_en    = 1'($urandom_range(0, 1));
      b.match_int_en  = 1'($urandom_range(0, 1));
      return b;
   endfunction

   // bursts of random length with random gaps in between
   task automatic run_traffic(input int count);
      int sent;
      int burst;
      sent = 0;
      while (sent < count) begin
         burst         = $urandom_range(1, 48);
         burst_compare = 8'($urandom_range(0, 153));
         burst_lcd_on  = ($urandom_range(0, 9) != 0);
         while (burst > 0 && sent < count) begin
            send_beat(random_beat());
            burst--;
            sent++;
         end
         if ($urandom_range(0, 3) != 0)
            sender_idle(($urandom_range(0, 9) == 0) ? $urandom_range(20, 40)
                                                     : $urandom_range(1, 8));
      end
      req_valid <= 1'b0;
   endtask

   // every prediction answered and the pipeline quiet
   task automatic wait_drained();
      while (timing_expect_q.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
   endtask

   // ---------------------------------------------------------------------------------
   // configuration port
   // ---------------------------------------------------------------------------------
   task automatic csr_write(input logic [2:0] addr, input logic [31:0] data);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= addr;
      csr_pwdata  <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      if (addr == ADDR_SCALED) tm_scaled = data[0];
      // leave the bus idle before the next transfer
      @(posedge clock);
   endtask

   task automatic csr_read_check(input logic [2:0] addr);
      logic [31:0] got;
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= addr;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      got = csr_prdata;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      if (got !== {31'd0, tm_scaled}) begin
         mismatches++;
         if (mismatches <= SHOWN_ERRS)
            $display("scaled_output readback: expected %0h actual %0h", tm_scaled, got);
      end
      // leave the bus idle before the next transfer
      @(posedge clock);
   endtask

   // ---------------------------------------------------------------------------------
   // tests
   // ---------------------------------------------------------------------------------

   // walk the first lines by hand: mode entries, irq enables, lcd off, compare extremes
   task automatic test_line_walk();
      timing_beat_type walk[$];
      csr_read_check(ADDR_SCALED);           // reset value
      csr_write(ADDR_SCALED, 32'd1);
      walk.push_back(mk_beat(8'd0,   1'b0, 8'd255, 1'b0, 1'b0, 1'b0)); // lcd off, zero step
      walk.push_back(mk_beat(8'd0,   1'b1, 8'd0,   1'b1, 1'b1, 1'b1)); // match on line zero
      walk.push_back(mk_beat(8'd80,  1'b1, 8'd0,   1'b1, 1'b1, 1'b1)); // last oam position
      walk.push_back(mk_beat(8'd1,   1'b1, 8'd255, 1'b0, 1'b0, 1'b1)); // transfer, clear match
      walk.push_back(mk_beat(8'd171, 1'b0, 8'd255, 1'b1, 1'b1, 1'b1)); // last transfer position
      walk.push_back(mk_beat(8'd1,   1'b1, 8'd0,   1'b1, 1'b0, 1'b0)); // hblank, line already drawn
      walk.push_back(mk_beat(8'd202, 1'b1, 8'd0,   1'b1, 1'b1, 1'b1)); // end of line
      walk.push_back(mk_beat(8'd1,   1'b1, 8'd0,   1'b1, 1'b1, 1'b1)); // wrap to oam
      walk.push_back(mk_beat(8'd255, 1'b1, 8'd1,   1'b1, 1'b1, 1'b1)); // hblank on line one
      walk.push_back(mk_beat(8'd255, 1'b1, 8'd2,   1'b0, 1'b1, 1'b0));
      walk.push_back(mk_beat(8'd255, 1'b0, 8'd2,   1'b1, 1'b0, 1'b1)); // hblank with lcd off
      walk.push_back(mk_beat(8'd255, 1'b1, 8'd3,   1'b1, 1'b1, 1'b1));
      walk.push_back(mk_beat(8'd255, 1'b1, 8'd3,   1'b1, 1'b1, 1'b1)); // first scaled line
      walk.push_back(mk_beat(8'd128, 1'b1, 8'd128, 1'b0, 1'b0, 1'b0));
      walk.push_back(mk_beat(8'd255, 1'b1, 8'd4,   1'b1, 1'b1, 1'b1));
      walk.push_back(mk_beat(8'd170, 1'b1, 8'd4,   1'b1, 1'b1, 1'b1));
      walk.push_back(mk_beat(8'd85,  1'b0, 8'd5,   1'b0, 1'b1, 1'b1));
      walk.push_back(mk_beat(8'd255, 1'b1, 8'd5,   1'b1, 1'b0, 1'b1));
      walk.push_back(mk_beat(8'd255, 1'b1, 8'd255, 1'b1, 1'b1, 1'b0));
      walk.push_back(mk_beat(8'd255, 1'b1, 8'd6,   1'b1, 1'b1, 1'b1));
      foreach (walk[i]) send_beat(walk[i]);
      req_valid <= 1'b0;
      wait_drained();
   endtask

   // unscaled display, with a write to the unused index that must change nothing
   task automatic test_unscaled_frames();
      csr_write(ADDR_SCALED, 32'd0);
      csr_write(ADDR_SPARE, 32'hFFFF_FFFF);
      csr_read_check(ADDR_SCALED);
      run_traffic(600);
      wait_drained();
   endtask

   // receiver holds off long enough for the block to fill and stall the request side
   task automatic test_output_backpressure();
      csr_write(ADDR_SCALED, 32'd1);
      csr_read_check(ADDR_SCALED);
      hold_off_asks++;
      run_traffic(450);
      wait_drained();
   endtask

   // only bit zero of the written word counts
   task automatic test_register_upper_bits();
      csr_write(ADDR_SCALED, 32'hFFFF_FFFE);
      csr_read_check(ADDR_SCALED);
      run_traffic(300);
      wait_drained();
      csr_write(ADDR_SCALED, 32'hFFFF_FFFF);
      csr_read_check(ADDR_SCALED);
      run_traffic(400);
      wait_drained();
   endtask

   initial begin
      tm_frame_pos  = '0;
      tm_line_pos   = '0;
      tm_line       = '0;
      tm_mode       = MODE_HBLANK;
      tm_match      = 1'b0;
      tm_skip       = '0;
      tm_last_drawn = '0;
      tm_frames     = '0;
      tm_scaled     = 1'b1;
      burst_compare = '0;
      burst_lcd_on  = 1'b1;

      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_line_walk();
      test_unscaled_frames();
      test_output_backpressure();
      test_register_upper_bits();

      if (mismatches == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
